### rtl/cmw_pkg.sv
// ----------------------------------------------------------------------------
// cmw_pkg
// Types, constants and helpers shared by the column melt wipe offset block.
// ----------------------------------------------------------------------------
package cmw_pkg;

	localparam int MAX_COLUMNS_DEF = 256;
	localparam int IMAGE_SCALE_DEF = 1;

	localparam int Y_W   = 12;
	localparam int H_W   = 11;
	localparam int C_W   = 9;
	localparam int ROW_W = 10;
	localparam int RND_W = 8;
	localparam int COL_W = 8;
	localparam int KIND_W = 2;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = H_W;

	localparam int SEED_SPAN  = 16;
	localparam int WALK_SPAN  = 3;
	localparam int SEED_FLOOR = -15;
	localparam int FALL_STEP  = 8;

	localparam logic [H_W-1:0] HEIGHT_RST = H_W'(200);
	localparam logic [C_W-1:0] COLUMNS_RST = C_W'(160);

	localparam logic [KIND_W-1:0] KIND_SEED  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_TICK  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_COLUMNS = 1'd1;

	typedef enum logic [2:0] {
		ALU_SEED  = 3'b001,
		ALU_TICK  = 3'b010,
		ALU_QUERY = 3'b100
	} alu_op_t;

	typedef struct packed {
		alu_op_t                  op;
		logic signed [Y_W-1:0]    y;
		logic [RND_W-1:0]         rnd;
		logic                     first;
		logic [H_W-1:0]           height;
		logic [ROW_W-1:0]         row;
	} alu_in_t;

	typedef struct packed {
		logic signed [Y_W-1:0]    y_new;
		logic                     moved;
		logic                     sel;
		logic [ROW_W-1:0]         row_out;
	} alu_out_t;

	// r mod 3 for a byte: pairs of bits weigh 1 mod 3
	function automatic logic [1:0] mod3_byte(input logic [RND_W-1:0] r);
		logic [3:0] s;
		logic [1:0] m;
		s = 4'(r[1:0]) + 4'(r[3:2]) + 4'(r[5:4]) + 4'(r[7:6]);
		case (s)
			4'd0, 4'd3, 4'd6, 4'd9, 4'd12: m = 2'd0;
			4'd1, 4'd4, 4'd7, 4'd10:       m = 2'd1;
			4'd2, 4'd5, 4'd8, 4'd11:       m = 2'd2;
			default:                       m = 2'd0;
		endcase
		return m;
	endfunction

endpackage

### rtl/column_melt_wipe_offsets.sv
// ----------------------------------------------------------------------------
// column_melt_wipe_offsets
// Per-column drop offsets for a column melt screen wipe: seed, tick, query.
// ----------------------------------------------------------------------------
//  channel  handshake               payload
//  in       in_valid / in_stall     kind, random_value, column, row
//  out      out_valid / out_stall   done_res, source_select, source_row
//  cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
//
//  Seed: offset written on acceptance. Query: offset RAM read, then row shift.
//  Tick: with N = min(active_columns, MAX_COLUMNS), the first N entries of the
//  offset RAM are walked one column a cycle through the shared offset unit.
//  Reset clears control state; offsets are undefined until seeded.
//  An item is taken only in idle; a waiting result holds under out_stall.
// ----------------------------------------------------------------------------
module column_melt_wipe_offsets
	import cmw_pkg::*;
#(
	parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
	parameter int IMAGE_SCALE = IMAGE_SCALE_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [KIND_W-1:0]     kind,
	input  logic [RND_W-1:0]      random_value,
	input  logic [COL_W-1:0]      column,
	input  logic [ROW_W-1:0]      row,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  done_res,
	output logic                  source_select,
	output logic [ROW_W-1:0]      source_row,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int AW    = $clog2(MAX_COLUMNS);
	localparam int CNT_W = $clog2(MAX_COLUMNS + 1);
	localparam int LW    = (CNT_W > C_W) ? CNT_W : C_W;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_TICK   = 4'b0010,
		S_QRD    = 4'b0100,
		S_RESULT = 4'b1000
	} state_t;

	state_t                state_q;
	logic [H_W-1:0]        height_q;
	logic [C_W-1:0]        active_q;
	logic [CNT_W-1:0]      seed_cnt_q;
	logic signed [Y_W-1:0] prev_q;
	logic [LW-1:0]         idx_q;
	logic                  rd_v_s1;
	logic [AW-1:0]         addr_s1;
	logic                  done_q;
	logic                  in_range_q;
	logic [ROW_W-1:0]      row_q;
	logic                  pend_done_q;
	logic                  pend_sel_q;
	logic [ROW_W-1:0]      pend_row_q;
	logic                  out_valid_q;
	logic                  out_done_q;
	logic                  out_sel_q;
	logic [ROW_W-1:0]      out_row_q;

	logic [LW-1:0]         n_cols;
	logic [LW-1:0]         col_ext;
	logic                  in_acc;
	logic                  seed_ok;
	logic                  rd_tick;
	logic                  tick_end;
	logic                  out_free;
	logic                  ram_we;
	logic [AW-1:0]         ram_wa;
	logic [Y_W-1:0]        ram_wd;
	logic                  ram_re;
	logic [AW-1:0]         ram_ra;
	logic [Y_W-1:0]        ram_rd;
	alu_in_t               alu_a;
	alu_out_t              alu_z;

	assign n_cols   = (LW'(active_q) < LW'(MAX_COLUMNS)) ? LW'(active_q) : LW'(MAX_COLUMNS);
	assign col_ext  = LW'(column);
	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign seed_ok  = (seed_cnt_q < CNT_W'(MAX_COLUMNS));
	assign rd_tick  = (state_q == S_TICK) && (idx_q < n_cols);
	assign tick_end = (state_q == S_TICK) && !rd_tick && !rd_v_s1;
	assign out_free = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;

	always_comb begin
		alu_a        = '0;
		alu_a.height = height_q;
		alu_a.rnd    = random_value;
		alu_a.first  = (seed_cnt_q == '0);
		alu_a.row    = row_q;
		case (state_q)
			S_TICK: begin
				alu_a.op = ALU_TICK;
				alu_a.y  = signed'(ram_rd);
			end
			S_QRD: begin
				alu_a.op = ALU_QUERY;
				alu_a.y  = signed'(ram_rd);
			end
			default: begin
				alu_a.op = ALU_SEED;
				alu_a.y  = prev_q;
			end
		endcase
	end

	cmw_alu #(
		.IMAGE_SCALE(IMAGE_SCALE)
	) u_alu (
		.a(alu_a),
		.z(alu_z)
	);

	always_comb begin
		ram_we = 1'b0;
		ram_wa = addr_s1;
		ram_wd = alu_z.y_new;
		ram_re = 1'b0;
		ram_ra = idx_q[AW-1:0];
		if (rd_v_s1) begin
			ram_we = 1'b1;
		end else if (in_acc && kind == KIND_SEED && seed_ok) begin
			ram_we = 1'b1;
			ram_wa = seed_cnt_q[AW-1:0];
		end
		if (rd_tick) begin
			ram_re = 1'b1;
		end else if (in_acc && kind == KIND_QUERY) begin
			ram_re = 1'b1;
			ram_ra = col_ext[AW-1:0];
		end
	end

	cmw_ram #(
		.WIDTH(Y_W),
		.DEPTH(MAX_COLUMNS)
	) u_ram (
		.clk(clk),
		.wr_en(ram_we),
		.wr_addr(ram_wa),
		.wr_data(ram_wd),
		.rd_en(ram_re),
		.rd_addr(ram_ra),
		.rd_data(ram_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q <= HEIGHT_RST;
			active_q <= COLUMNS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SCREEN_HEIGHT:  height_q <= cfg_data;
				REG_ACTIVE_COLUMNS: active_q <= cfg_data[C_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			seed_cnt_q  <= '0;
			idx_q       <= '0;
			rd_v_s1     <= 1'b0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_v_s1 <= rd_tick;
			if (rd_tick) begin
				idx_q <= idx_q + LW'(1);
			end
			if (rd_v_s1 && alu_z.moved) begin
				done_q <= 1'b0;
			end
			if (state_q == S_RESULT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						case (kind)
							KIND_SEED: begin
								if (seed_ok) begin
									seed_cnt_q <= seed_cnt_q + CNT_W'(1);
								end
								state_q <= S_RESULT;
							end
							KIND_TICK: begin
								seed_cnt_q <= '0;
								idx_q      <= '0;
								done_q     <= 1'b1;
								state_q    <= S_TICK;
							end
							KIND_QUERY: begin
								state_q <= S_QRD;
							end
							default: begin
								state_q <= S_RESULT;
							end
						endcase
					end
				end
				S_TICK: begin
					if (tick_end) begin
						state_q <= S_RESULT;
					end
				end
				S_QRD: begin
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= idx_q[AW-1:0];
		if (in_acc) begin
			row_q       <= row;
			in_range_q  <= (col_ext < n_cols);
			pend_done_q <= 1'b0;
			pend_sel_q  <= 1'b0;
			pend_row_q  <= '0;
		end
		if (in_acc && kind == KIND_SEED && seed_ok) begin
			prev_q <= alu_z.y_new;
		end
		if (tick_end) begin
			pend_done_q <= done_q;
		end
		if (state_q == S_QRD) begin
			if (in_range_q) begin
				pend_sel_q <= alu_z.sel;
				pend_row_q <= alu_z.row_out;
			end else begin
				pend_sel_q <= 1'b0;
				pend_row_q <= row_q;
			end
		end
		if (state_q == S_RESULT && out_free) begin
			out_done_q <= pend_done_q;
			out_sel_q  <= pend_sel_q;
			out_row_q  <= pend_row_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign done_res      = out_done_q;
	assign source_select = out_sel_q;
	assign source_row    = out_row_q;

	a_tick_clears_seed: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && kind == KIND_TICK |=> seed_cnt_q == '0 && state_q == S_TICK)
		else $error("tick did not clear seed count");

	a_out_from_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_RESULT))
		else $error("result loaded outside result state");

	a_walk_in_tick: assert property (@(posedge clk) disable iff (!arst_n)
		rd_v_s1 |-> state_q == S_TICK && $past(idx_q < n_cols))
		else $error("offset write-back outside tick walk");

	a_query_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_QRD |-> $past(state_q == S_IDLE) && $past(ram_re))
		else $error("query without offset read");

endmodule

### rtl/cmw_ram.sv
// ----------------------------------------------------------------------------
// cmw_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module cmw_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### rtl/cmw_alu.sv
// ----------------------------------------------------------------------------
// cmw_alu
// Shared offset unit: seed walk step, tick fall step and pixel row shift.
// ----------------------------------------------------------------------------
module cmw_alu
	import cmw_pkg::*;
#(
	parameter int IMAGE_SCALE = IMAGE_SCALE_DEF
) (
	input  alu_in_t  a,
	output alu_out_t z
);

	localparam logic signed [Y_W-1:0] FAST_LIMIT = Y_W'(SEED_SPAN * IMAGE_SCALE);
	localparam logic signed [Y_W-1:0] SLOW_STEP  = Y_W'(FALL_STEP * IMAGE_SCALE);
	localparam logic signed [Y_W-1:0] FLOOR_V    = Y_W'(SEED_FLOOR);
	localparam logic signed [Y_W-1:0] WRAP_V     = Y_W'(SEED_FLOOR - 1);

	logic signed [Y_W-1:0] h_s;
	logic signed [Y_W-1:0] walk;
	logic signed [Y_W-1:0] seed_v;
	logic signed [Y_W-1:0] dy;
	logic [Y_W:0]          sum;
	logic [H_W-1:0]        e;
	logic [H_W-1:0]        diff;

	always_comb begin
		h_s  = signed'({1'b0, a.height});
		walk = a.y + signed'(Y_W'(mod3_byte(a.rnd))) - Y_W'(1);
		if (a.first) begin
			seed_v = -signed'(Y_W'(a.rnd[3:0]));
		end else if (walk > 0) begin
			seed_v = '0;
		end else if (walk == WRAP_V) begin
			seed_v = FLOOR_V;
		end else begin
			seed_v = walk;
		end

		dy  = (a.y < FAST_LIMIT) ? a.y + Y_W'(1) : SLOW_STEP;
		sum = (Y_W+1)'(unsigned'(a.y)) + (Y_W+1)'(unsigned'(dy));

		e    = a.y[Y_W-1] ? '0 : a.y[H_W-1:0];
		diff = H_W'(a.row) - e;

		z = '0;
		case (a.op)
			ALU_SEED: begin
				z.y_new = seed_v;
			end
			ALU_TICK: begin
				if (a.y < 0) begin
					z.y_new = a.y + Y_W'(1);
					z.moved = 1'b1;
				end else if (a.y < h_s) begin
					z.moved = 1'b1;
					if (sum >= (Y_W+1)'(a.height)) begin
						z.y_new = h_s;
					end else begin
						z.y_new = signed'(sum[Y_W-1:0]);
					end
				end else begin
					z.y_new = a.y;
				end
			end
			ALU_QUERY: begin
				if (H_W'(a.row) < e) begin
					z.sel     = 1'b1;
					z.row_out = a.row;
				end else begin
					z.row_out = diff[ROW_W-1:0];
				end
			end
			default: begin
				z = '0;
			end
		endcase
	end

endmodule
